// ----- rtl/core/gos_pkg.sv -----
// Shared types and constants for the grid obstacle skirt block.
// No dependencies; used by every module of the block.
package gos_pkg;

   // Largest grid dimension the counters and result fields can carry
   localparam int unsigned GRID_MAX = 256;
   localparam int unsigned MAX_WIDTH_DEF = 256;

   localparam int unsigned COST_W = 8;
   localparam int unsigned DIM_W = 9;
   localparam int unsigned COORD_W = 8;

   // Register map, by word index
   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BLOCKED = 2'd2;
   localparam logic [1:0] REG_SKIRT = 2'd3;

   localparam logic [DIM_W-1:0] WIDTH_RST = 9'd64;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd64;
   localparam logic [COST_W-1:0] BLOCKED_RST = 8'd255;
   localparam logic [COST_W-1:0] SKIRT_RST = 8'd8;

   // Input beat kinds
   localparam logic FUNC_CELL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Effective geometry and costs as seen by the datapath
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [COST_W-1:0] blocked;
      logic [COST_W-1:0] skirt;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [COST_W-1:0] new_cost;
      logic last_cell;
   } result_type;

endpackage

// ----- rtl/core/gos_csr.sv -----
// Configuration registers of the grid obstacle skirt, APB-style write/read.
// Depends on gos_pkg; produces clamped geometry and the stream restart pulse.
module gos_csr #(
   parameter int unsigned MAX_WIDTH = gos_pkg::MAX_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output gos_pkg::cfg_type cfg,
   output logic restart
);

   localparam int unsigned WIDTH_LIMIT =
      (MAX_WIDTH < gos_pkg::GRID_MAX) ? MAX_WIDTH : gos_pkg::GRID_MAX;

   logic [gos_pkg::DIM_W-1:0] width_ff, width_in;
   logic [gos_pkg::DIM_W-1:0] height_ff, height_in;
   logic [gos_pkg::COST_W-1:0] blocked_ff, blocked_in;
   logic [gos_pkg::COST_W-1:0] skirt_ff, skirt_in;
   logic wr;
   logic [1:0] idx;

   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      blocked_in = blocked_ff;
      skirt_in = skirt_ff;
      restart = 1'b0;
      if (wr) begin
         unique case (idx)
            gos_pkg::REG_WIDTH: begin
               width_in = csr_pwdata[gos_pkg::DIM_W-1:0];
               restart = 1'b1;
            end
            gos_pkg::REG_HEIGHT: begin
               height_in = csr_pwdata[gos_pkg::DIM_W-1:0];
               restart = 1'b1;
            end
            gos_pkg::REG_BLOCKED: blocked_in = csr_pwdata[gos_pkg::COST_W-1:0];
            gos_pkg::REG_SKIRT: skirt_in = csr_pwdata[gos_pkg::COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= gos_pkg::WIDTH_RST;
         height_ff <= gos_pkg::HEIGHT_RST;
         blocked_ff <= gos_pkg::BLOCKED_RST;
         skirt_ff <= gos_pkg::SKIRT_RST;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         blocked_ff <= blocked_in;
         skirt_ff <= skirt_in;
      end
   end

   always_comb begin
      unique case (idx)
         gos_pkg::REG_WIDTH: csr_prdata = 32'(width_ff);
         gos_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         gos_pkg::REG_BLOCKED: csr_prdata = 32'(blocked_ff);
         gos_pkg::REG_SKIRT: csr_prdata = 32'(skirt_ff);
         default: csr_prdata = '0;
      endcase
   end

   // Zero acts as one; clamp to the grid limit and the line buffer depth
   always_comb begin
      cfg.blocked = blocked_ff;
      cfg.skirt = skirt_ff;
      if (width_ff == '0) begin
         cfg.width = gos_pkg::DIM_W'(1);
      end else if (width_ff > gos_pkg::DIM_W'(WIDTH_LIMIT)) begin
         cfg.width = gos_pkg::DIM_W'(WIDTH_LIMIT);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = gos_pkg::DIM_W'(1);
      end else if (height_ff > gos_pkg::DIM_W'(gos_pkg::GRID_MAX)) begin
         cfg.height = gos_pkg::DIM_W'(gos_pkg::GRID_MAX);
      end else begin
         cfg.height = height_ff;
      end
   end

endmodule

// ----- rtl/core/gos_linebuf.sv -----
// Two-row line buffer: one synchronous memory holding {upper, middle} per column.
// Depends on gos_pkg; registered read with write-to-read forwarding.
module gos_linebuf #(
   parameter int unsigned MAX_WIDTH = gos_pkg::MAX_WIDTH_DEF,
   parameter int unsigned AW = $clog2(MAX_WIDTH)
) (
   input  logic clock,
   input  logic reset,
   input  logic [AW-1:0] rd_addr,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [2*gos_pkg::COST_W-1:0] wr_data,
   output logic [2*gos_pkg::COST_W-1:0] rd_data
);

   logic [2*gos_pkg::COST_W-1:0] mem [MAX_WIDTH];
   logic [2*gos_pkg::COST_W-1:0] rd_q_ff;
   logic [2*gos_pkg::COST_W-1:0] fwd_data_ff;
   logic fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
      fwd_data_ff <= wr_data;
   end

   // Same-entry write in the read cycle: the memory returns stale data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

// ----- rtl/core/gos_window.sv -----
// Raster counters, 3x3 window and skirt decision for the grid obstacle skirt.
// Depends on gos_pkg and gos_linebuf.
module gos_window #(
   parameter int unsigned MAX_WIDTH = gos_pkg::MAX_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  gos_pkg::cfg_type cfg,
   input  logic restart,
   input  logic accept,
   input  logic func,
   input  logic [gos_pkg::COST_W-1:0] cell_cost,
   output logic res_valid,
   output gos_pkg::result_type res
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned CW = gos_pkg::COORD_W;
   localparam int unsigned DW = gos_pkg::DIM_W;

   logic [CW-1:0] col_ff, col_in;
   logic [DW-1:0] row_ff, row_in;
   // 0/1 top older/newer, 2/3 mid, 4/5 bottom
   logic [gos_pkg::COST_W-1:0] win_ff [6];
   logic [gos_pkg::COST_W-1:0] win_in [6];

   logic [2*gos_pkg::COST_W-1:0] rd_data;
   logic [gos_pkg::COST_W-1:0] rd_upper, rd_middle;
   logic [gos_pkg::COST_W-1:0] top, mid, bot, own, b;
   logic [DW:0] row_x, h_plus1;
   logic in_grid, step, emit, last, touches, raise;
   logic [DW-1:0] col_inc;

   assign b = cfg.blocked;
   assign rd_upper = rd_data[2*gos_pkg::COST_W-1:gos_pkg::COST_W];
   assign rd_middle = rd_data[gos_pkg::COST_W-1:0];

   assign row_x = {1'b0, row_ff};
   assign h_plus1 = {1'b0, cfg.height} + (DW+1)'(1);
   assign in_grid = row_ff < cfg.height;
   // Drain beats inside the grid are swallowed without advancing
   assign step = accept && !(in_grid && func == gos_pkg::FUNC_DRAIN);

   assign top = (row_ff < DW'(2)) ? b : rd_upper;
   assign mid = (row_ff == '0 || row_x >= h_plus1) ? b : rd_middle;
   assign bot = in_grid ? cell_cost : b;

   assign emit = (row_ff >= DW'(2)) || (row_ff == DW'(1) && col_ff != '0);
   assign last = (row_x == h_plus1) && (col_ff == '0);

   always_comb begin
      own = win_ff[3];
      if (col_ff == '0 || col_ff == CW'(1)) begin
         touches = 1'b1;
      end else begin
         touches = win_ff[0] == b || win_ff[1] == b || top == b ||
                   win_ff[2] == b || mid == b ||
                   win_ff[4] == b || win_ff[5] == b || bot == b;
      end
      raise = (own != b) && touches && (own < cfg.skirt);
      res.new_cost = raise ? cfg.skirt : own;
      res.last_cell = last;
      if (col_ff == '0) begin
         res.out_col = CW'(cfg.width - DW'(1));
         res.out_row = CW'(row_ff - DW'(2));
      end else begin
         res.out_col = col_ff - CW'(1);
         res.out_row = CW'(row_ff - DW'(1));
      end
   end

   assign res_valid = step && emit;
   assign col_inc = {1'b0, col_ff} + DW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      if (restart || (step && emit && last)) begin
         col_in = '0;
         row_in = '0;
         for (int i = 0; i < 6; i++) begin
            win_in[i] = '0;
         end
      end else if (step) begin
         win_in[0] = win_ff[1];
         win_in[1] = top;
         win_in[2] = win_ff[3];
         win_in[3] = mid;
         win_in[4] = win_ff[5];
         win_in[5] = bot;
         if (col_inc >= cfg.width) begin
            col_in = '0;
            row_in = row_ff + DW'(1);
         end else begin
            col_in = CW'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // Prefetch the next column so its rows are ready when the beat arrives
   gos_linebuf #(
      .MAX_WIDTH(MAX_WIDTH),
      .AW(AW)
   ) u_linebuf (
      .clock(clock),
      .reset(reset),
      .rd_addr(AW'(col_in)),
      .wr_en(step),
      .wr_addr(AW'(col_ff)),
      .wr_data({rd_middle, bot}),
      .rd_data(rd_data)
   );

endmodule

// ----- rtl/core/grid_obstacle_skirt_top.sv -----
// Top level of the grid obstacle skirt: cost stream in, skirted stream out.
// Depends on gos_pkg, gos_csr, gos_window (which holds gos_linebuf).
//
//  channel  dir   handshake               payload
//  req_     in    tvalid/tready           tdata = cell_cost, tuser = func
//  rsp_     out   tvalid/tready           tdata = {out_row,out_col,new_cost}, tlast
//  csr_     in    psel/penable/pready     paddr/pwdata/prdata, 4 regs at 4*i
//
// One beat per cycle unless the output stalls; each beat is one cell (or drain
// tick) and the result it completes leaves the output register the cycle after
// acceptance. The line buffer is read one column ahead, so its read keeps pace.
// Results lag the input by one row plus one cell; width+1 drain beats flush.
// Synchronous active-high reset clears counters, window and output valid;
// line buffer contents stay undefined and no clearing pass is needed.
// A stalled output holds req_tready low only while its register is full.
module grid_obstacle_skirt_top #(
   parameter int unsigned MAX_WIDTH = gos_pkg::MAX_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // input stream
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] cell_cost
   input  logic req_tuser,         // [0] func
   // result stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] new_cost, [15:8] out_col, [23:16] out_row
   output logic rsp_tlast,         // last_cell
   // configuration
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   gos_pkg::cfg_type cfg;
   gos_pkg::result_type res;
   gos_pkg::result_type rsp_ff, rsp_in;
   logic restart;
   logic accept;
   logic res_valid;
   logic rsp_valid_ff, rsp_valid_in;

   assign csr_pready = 1'b1;

   gos_csr #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .cfg(cfg),
      .restart(restart)
   );

   // Take a beat whenever the output register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   gos_window #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .restart(restart),
      .accept(accept),
      .func(req_tuser),
      .cell_cost(req_tdata),
      .res_valid(res_valid),
      .res(res)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (accept && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_ff.out_row, rsp_ff.out_col, rsp_ff.new_cost};
   assign rsp_tlast = rsp_ff.last_cell;

   // Final cell of a grid is the bottom-right corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_cell |->
         (9'(rsp_ff.out_col) == cfg.width - 9'd1) &&
         (9'(rsp_ff.out_row) == cfg.height - 9'd1))
      else $error("last cell is not the grid corner");

   // Emitted coordinates stay inside the grid
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 9'(rsp_ff.out_col) < cfg.width)
      else $error("result column outside grid");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 9'(rsp_ff.out_row) < cfg.height)
      else $error("result row outside grid");

   // A waiting result is never overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_ff))
      else $error("held result changed");

endmodule

// ----- tb/grid_obstacle_skirt_top_tb.sv -----
// Self-checking testbench for grid_obstacle_skirt_top: raster cost beats in, skirted beats out.
// Depends on gos_pkg and the grid_obstacle_skirt_top RTL; a built-in skirt predictor checks
// every result.
`timescale 1ns / 1ps

module grid_obstacle_skirt_top_tb;

   localparam int unsigned CYCLE_LIMIT = 500_000;
   localparam int unsigned RANDOM_BEATS = 200;
   localparam int unsigned DRAIN_CYCLES = 4;   // result leaves in the cycle after accept

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;            // [7:0] cell_cost
   logic req_tuser = gos_pkg::FUNC_CELL;  // [0] func
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // [7:0] new_cost, [15:8] out_col, [23:16] out_row
   logic rsp_tlast;              // last_cell
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   grid_obstacle_skirt_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial forever #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Skirt predictor: its own copy of config, line stores, 3x3 window
   // and raster counters. Results go into expected_cells in order.
   // ---------------------------------------------------------------
   logic [8:0] cfg_width = gos_pkg::WIDTH_RST;
   logic [8:0] cfg_height = gos_pkg::HEIGHT_RST;
   logic [7:0] cfg_blocked = gos_pkg::BLOCKED_RST;
   logic [7:0] cfg_skirt = gos_pkg::SKIRT_RST;
   logic [7:0] upper_row [256];
   logic [7:0] middle_row [256];
   // window: [0]/[1] top row old/new, [2]/[3] middle, [4]/[5] bottom
   logic [7:0] win [6];
   int unsigned col_cnt, row_cnt, emit_cnt;
   gos_pkg::result_type expected_cells [$];

   int unsigned errors = 0;
   int unsigned beats_sent = 0;
   int unsigned grid_beats = 0;
   int unsigned results_checked = 0;
   int unsigned grids_done = 0;
   int unsigned cycle_count = 0;
   bit idle_on = 1'b1;     // random gaps and stalls on both sides
   bit req_held = 1'b0;    // req_tvalid left high for a back-to-back beat
   int unsigned next_gap = 0;

   initial begin
      for (int i = 0; i < 256; i++) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      emit_cnt = 0;
   end

   // 0 acts as 1, anything past 256 is capped (MAX_WIDTH default is 256 too)
   function automatic int unsigned eff_dim(input logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic void restart_stream();
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      emit_cnt = 0;
   endfunction

   function automatic void skirt_predict(input logic func, input logic [7:0] cost);
      int unsigned w, h, total, b, r, c, pos, top, mid, bot, own, e;
      bit in_grid, touches, emitted;
      gos_pkg::result_type res;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      total = w * h;
      b = cfg_blocked;
      r = row_cnt;
      c = col_cnt;
      pos = r * w + c;
      in_grid = pos < total;
      emitted = 1'b0;
      if (c >= w) c = 0;
      // drain tick while cells are still due: ignored, no advance
      if (in_grid && func == gos_pkg::FUNC_DRAIN) return;
      top = (r < 2) ? b : upper_row[c];
      mid = (r < 1 || r - 1 >= h) ? b : middle_row[c];
      bot = in_grid ? cost : b;   // past the grid a cell acts as a drain
      if (pos >= w + 1 && emit_cnt < total) begin
         e = pos - w - 1;
         own = win[3];
         // c==0: emitted cell sits on the right border; c==1: on the left
         touches = (c <= 1) ||
                   win[0] == b || win[1] == b || top == b ||
                   win[2] == b || mid == b ||
                   win[4] == b || win[5] == b || bot == b;
         if (own != b && touches && own < cfg_skirt) own = cfg_skirt;
         res.new_cost = 8'(own);
         res.out_col = 8'(e % w);
         res.out_row = 8'(e / w);
         res.last_cell = (emit_cnt + 1 == total);
         expected_cells.push_back(res);
         emit_cnt++;
         emitted = 1'b1;
      end
      upper_row[c] = middle_row[c];
      middle_row[c] = 8'(bot);
      win[0] = win[1]; win[1] = 8'(top);
      win[2] = win[3]; win[3] = 8'(mid);
      win[4] = win[5]; win[5] = 8'(bot);
      if (emitted && emit_cnt >= total) begin
         restart_stream();   // last cell out: next beat starts a new grid
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         col_cnt = c;
         row_cnt = r;
      end
   endfunction

   function automatic logic [31:0] cfg_value(input logic [1:0] idx);
      case (idx)
         gos_pkg::REG_WIDTH: return {23'd0, cfg_width};
         gos_pkg::REG_HEIGHT: return {23'd0, cfg_height};
         gos_pkg::REG_BLOCKED: return {24'd0, cfg_blocked};
         default: return {24'd0, cfg_skirt};
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Config port: setup cycle, access cycle, done when pready is high.
   // ---------------------------------------------------------------
   task automatic csr_xfer(input bit is_write, input logic [1:0] idx,
                           input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      logic [31:0] unused;
      csr_xfer(1'b1, idx, data, unused);
      case (idx)
         gos_pkg::REG_WIDTH: begin
            cfg_width = data[8:0];
            restart_stream();
         end
         gos_pkg::REG_HEIGHT: begin
            cfg_height = data[8:0];
            restart_stream();
         end
         gos_pkg::REG_BLOCKED: cfg_blocked = data[7:0];
         default: cfg_skirt = data[7:0];
      endcase
   endtask

   task automatic csr_check_all();
      logic [31:0] rd;
      for (int i = 0; i < 4; i++) begin
         csr_xfer(1'b0, 2'(i), $urandom, rd);
         if (rd !== cfg_value(2'(i))) begin
            $error("csr reg %0d: expected %0h, got %0h", i, cfg_value(2'(i)), rd);
            errors++;
         end
      end
   endtask

   // Garbage above the field width must be dropped by the register
   task automatic program_grid(input logic [8:0] w, input logic [8:0] h,
                               input logic [7:0] blk, input logic [7:0] skirt);
      csr_write(gos_pkg::REG_WIDTH, ($urandom & ~32'h1FF) | w);
      csr_write(gos_pkg::REG_HEIGHT, ($urandom & ~32'h1FF) | h);
      csr_write(gos_pkg::REG_BLOCKED, ($urandom & ~32'hFF) | blk);
      csr_write(gos_pkg::REG_SKIRT, ($urandom & ~32'hFF) | skirt);
      csr_check_all();
   endtask

   // ---------------------------------------------------------------
   // Input side. The gap before the next beat is drawn at acceptance;
   // with no gap, tvalid simply stays high. release_req drops it when
   // the sender stops.
   // ---------------------------------------------------------------
   task automatic send_beat(input logic func, input logic [7:0] cost);
      if (!req_held) repeat (next_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= cost;
      req_tuser <= func;
      do @(posedge clock); while (req_tready !== 1'b1);
      skirt_predict(func, cost);
      beats_sent++;
      next_gap = idle_on ? $urandom_range(0, 10) : 0;
      if (next_gap > 0) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end else begin
         req_held = 1'b1;
      end
   endtask

   task automatic release_req();
      if (req_held) req_tvalid <= 1'b0;
      req_held = 1'b0;
      @(posedge clock);
   endtask

   task automatic pause_until_drained();
      release_req();
      while (expected_cells.size() != 0) @(posedge clock);
   endtask

   // Drain beats give no result, so give the pipe a few more cycles
   task automatic wait_idle();
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_cost(input int unsigned blk_pct);
      if ($urandom_range(0, 99) < blk_pct) return cfg_blocked;
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd255;
         2: return cfg_skirt + 8'($urandom_range(0, 2)) - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   // One grid from its first cell; noisy adds ignored drains, mid-grid
   // pauses and surplus drains. A partial grid stops short of the flush.
   task automatic run_grid(input int unsigned blk_pct, input bit full, input bit noisy);
      int unsigned w, total, n;
      w = eff_dim(cfg_width);
      total = w * eff_dim(cfg_height);
      n = full ? total : $urandom_range(0, total - 1);
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 19) == 0)
            send_beat(gos_pkg::FUNC_DRAIN, 8'($urandom));
         if (noisy && $urandom_range(0, 49) == 0) pause_until_drained();
         send_beat(gos_pkg::FUNC_CELL, pick_cost(blk_pct));
         grid_beats++;
      end
      if (full) begin
         // flush: some as cells past the end, which act as drains
         for (int unsigned i = 0; i <= w; i++) begin
            send_beat(($urandom_range(0, 3) == 0) ? gos_pkg::FUNC_CELL : gos_pkg::FUNC_DRAIN,
                      8'($urandom));
            grid_beats++;
         end
         if (noisy && $urandom_range(0, 2) == 0)
            send_beat(gos_pkg::FUNC_DRAIN, 8'($urandom));
         grids_done++;
      end
   endtask

   // ---------------------------------------------------------------
   // Output side: random stall per result, then compare with the
   // oldest expectation field by field.
   // ---------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   initial begin
      int unsigned stall;
      gos_pkg::result_type exp_cell;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (expected_cells.size() == 0) begin
            $error("unexpected result beat: tdata %0h tlast %0b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            exp_cell = expected_cells.pop_front();
            check_field("new_cost", 32'(exp_cell.new_cost), 32'(rsp_tdata[7:0]));
            check_field("out_col", 32'(exp_cell.out_col), 32'(rsp_tdata[15:8]));
            check_field("out_row", 32'(exp_cell.out_row), 32'(rsp_tdata[23:16]));
            check_field("last_cell", 32'(exp_cell.last_cell), 32'(rsp_tlast));
            results_checked++;
         end
      end
   end

   // Run-away guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_register_access();
      csr_check_all();   // reset values
      program_grid(9'h1FF, 9'd300, 8'hA5, 8'h5A);
      program_grid(9'd0, 9'd0, 8'd255, 8'd8);
   endtask

   // 0x0 geometry acts as 1x1; a lone cell is always on the border.
   // First flush beat is a cell past the end, the second a drain, then a surplus drain.
   task automatic test_single_cell();
      program_grid(9'd0, 9'd0, 8'd255, 8'd8);
      send_beat(gos_pkg::FUNC_CELL, 8'd0);
      send_beat(gos_pkg::FUNC_CELL, 8'd255);
      send_beat(gos_pkg::FUNC_DRAIN, 8'd17);
      send_beat(gos_pkg::FUNC_DRAIN, 8'd99);
      wait_idle();
   endtask

   // Blocked code 0, skirt 255; a drain tick in the middle is ignored
   task automatic test_ignored_drain();
      program_grid(9'd3, 9'd2, 8'd0, 8'd255);
      send_beat(gos_pkg::FUNC_CELL, 8'd255);
      send_beat(gos_pkg::FUNC_CELL, 8'd0);
      send_beat(gos_pkg::FUNC_CELL, 8'd128);
      send_beat(gos_pkg::FUNC_DRAIN, 8'd77);
      send_beat(gos_pkg::FUNC_CELL, 8'd1);
      send_beat(gos_pkg::FUNC_CELL, 8'd254);
      send_beat(gos_pkg::FUNC_CELL, 8'd0);
      for (int i = 0; i < 4; i++) send_beat(gos_pkg::FUNC_DRAIN, 8'd0);
      wait_idle();
   endtask

   // Geometry rewritten with part of a grid in flight restarts the stream
   task automatic test_midgrid_restart();
      program_grid(9'd3, 9'd2, 8'd200, 8'd100);
      for (int i = 0; i < 4; i++)
         send_beat(gos_pkg::FUNC_CELL, (i == 2) ? 8'd200 : 8'(i * 60));
      wait_idle();
      csr_write(gos_pkg::REG_HEIGHT, 32'd1);
      csr_check_all();
      for (int i = 0; i < 3; i++) send_beat(gos_pkg::FUNC_CELL, 8'(i * 90 + 5));
      for (int i = 0; i < 4; i++) send_beat(gos_pkg::FUNC_DRAIN, 8'd0);
      wait_idle();
   endtask

   // Full-width row and full-height column with extreme cost codes
   task automatic test_extreme_geometry();
      program_grid(9'd256, 9'd0, 8'd255, 8'd255);
      run_grid(30, 1'b1, 1'b0);
      wait_idle();
      program_grid(9'd1, 9'd511, 8'd0, 8'd0);
      run_grid(40, 1'b1, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_grids();
      int unsigned start, w, h;
      logic [7:0] blk, skirt;
      bit full;
      bit stream_clean;
      start = grid_beats;
      stream_clean = 1'b1;
      while (grid_beats - start < RANDOM_BEATS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (!stream_clean || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 15))
               0: w = 0;
               1, 2: w = $urandom_range(13, 40);
               default: w = $urandom_range(1, 12);
            endcase
            if (w > 12) h = $urandom_range(1, 4);
            else case ($urandom_range(0, 9))
               0: h = 0;
               1: h = $urandom_range(9, 20);
               default: h = $urandom_range(1, 8);
            endcase
            blk = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                              : 8'($urandom);
            skirt = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                                : 8'($urandom);
            program_grid(9'(w), 9'(h), blk, skirt);
         end
         full = ($urandom_range(0, 9) != 0);
         run_grid($urandom_range(0, 60), full, 1'b1);
         stream_clean = full;
         wait_idle();
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence: reset once, then each test in turn.
   // ---------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_single_cell();
      test_ignored_drain();
      test_midgrid_restart();
      test_extreme_geometry();
      test_random_grids();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Checked %0d skirted cells from %0d input beats over %0d complete grids.",
               results_checked, beats_sent, grids_done);
      $display("Geometry 1x1 up to 256 wide or tall, mid-grid restarts, ignored drains.");
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- grid_obstacle_skirt_top.f -----
rtl/core/gos_pkg.sv
rtl/core/gos_csr.sv
rtl/core/gos_linebuf.sv
rtl/core/gos_window.sv
rtl/core/grid_obstacle_skirt_top.sv
tb/grid_obstacle_skirt_top_tb.sv
